// ===== hdl/entry_pool_queue_manager_assert.svh =====
// assertion macros for the entry pool queue manager
// used by the top level only; no other dependencies
`ifndef ENTRY_POOL_QUEUE_MANAGER_ASSERT_SVH
`define ENTRY_POOL_QUEUE_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define EPQM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("epqm assertion failed");
// next-cycle implication, checked outside reset
`define EPQM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("epqm assertion failed");
`else
`define EPQM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define EPQM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/epqm_pkg.sv =====
// types, constants and helper functions of the entry pool queue manager
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package epqm_pkg;

  // pool size and derived widths
  parameter int unsigned Entries = 32;
  parameter int unsigned IdxW    = $clog2(Entries);
  parameter int unsigned StepW   = $clog2(Entries + 1);

  // operation codes
  typedef enum logic [2:0] {
    OP_ALLOC    = 3'd0,
    OP_FREE     = 3'd1,
    OP_APPEND   = 3'd2,
    OP_PEEK     = 3'd3,
    OP_RM_HEAD  = 3'd4,
    OP_RM_NAMED = 3'd5
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_LINK,
    S_WALK,
    S_UNLINK,
    S_INSERT
  } state_e;

  // input item
  typedef struct packed {
    logic [2:0]      operation;
    logic            tail_present;
    logic [IdxW-1:0] tail_index;
    logic [IdxW-1:0] entry_index;
  } req_t;

  // result item
  typedef struct packed {
    logic            result_present;
    logic [IdxW-1:0] result_index;
    logic            new_tail_present;
    logic [IdxW-1:0] new_tail_index;
  } rsp_t;

  // next link of an entry never written since reset
  function automatic logic [IdxW-1:0] next_reset(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] res;
    res = (idx == IdxW'(Entries - 1)) ? '0 : idx + 1'b1;
    return res;
  endfunction

  // previous link of an entry never written since reset
  function automatic logic [IdxW-1:0] prev_reset(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] res;
    res = (idx == '0) ? IdxW'(Entries - 1) : idx - 1'b1;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/epqm_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module epqm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/entry_pool_queue_manager.sv =====
// top level of the entry pool queue manager: sequencer and link memories
// depends on epqm_pkg, epqm_ram and entry_pool_queue_manager_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "entry_pool_queue_manager_assert.svh"

// Entry pool queue manager: one free list and any number of caller-held
// queues, all built from per-entry next and previous links.
// Command channel: an item (req_i) is taken on a rising edge with start high
// and busy low. busy stays high until the work is done.
// Result channel: each item gives exactly one result on rsp_o, marked by
// valid_o for a single cycle. The receiver cannot stall; the result is simply
// taken at the end of that cycle.
// Path through the sequencer states: allocate or free with an empty free list
// and empty-queue cases end after START; peek and allocating the last free
// entry go through LINK, removing a named tail through UNLINK; allocate,
// free, append and remove head go through LINK and then UNLINK or INSERT;
// remove named by walking takes one WALK step per entry passed before UNLINK,
// or ends in WALK when the tail is reached. Every step waits on the registered
// read of the link memories, which have one read and one write port each.
// busy falls in the strobe cycle, so the next item can be taken then.
// Reset (rst_ni low, asynchronous) frees every entry in order 0, 1, 2, ...
// Per-entry valid bits stand in for the reset contents of the links, so there
// is no clearing pass after reset.
module entry_pool_queue_manager (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire epqm_pkg::req_t req_i,
  output logic               valid_o,
  output epqm_pkg::rsp_t     rsp_o
);

  localparam int unsigned IdxW  = epqm_pkg::IdxW;
  localparam int unsigned StepW = epqm_pkg::StepW;

  epqm_pkg::state_e state_q, state_d;
  logic [2:0]       op_q;
  logic             tp_q;
  logic [IdxW-1:0]  t_q, e_q;
  logic [IdxW-1:0]  anchor_q, anchor_d;
  logic             free_empty_q, free_empty_d;
  logic [StepW-1:0] steps_q, steps_d;
  logic [IdxW-1:0]  n_q, n_d;
  epqm_pkg::rsp_t   res_q, res_d;
  logic             done_q;
  logic             accept;

  // link memory ports
  logic            nx_we, pv_we;
  logic [IdxW-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic [IdxW-1:0] pv_waddr, pv_wdata, pv_raddr, pv_rdata;
  logic [epqm_pkg::Entries-1:0] nx_vld_q, pv_vld_q;
  logic [IdxW-1:0] nx_raddr_q, pv_raddr_q;
  logic            nx_rvld_q, pv_rvld_q;
  logic [IdxW-1:0] rd_next, rd_prev;

  // shared decode
  epqm_pkg::op_e op_cur;
  logic          named_self, hit_anchor, walk_end, walk_hit, prev_is_tail;
  logic [IdxW-1:0] ins_base;

  assign accept = start && !busy;
  assign busy   = (state_q != epqm_pkg::S_IDLE);

  epqm_ram #(.Width(IdxW), .Depth(epqm_pkg::Entries)) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (nx_we),
    .waddr_i(nx_waddr),
    .wdata_i(nx_wdata),
    .raddr_i(nx_raddr),
    .rdata_o(nx_rdata)
  );

  epqm_ram #(.Width(IdxW), .Depth(epqm_pkg::Entries)) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (pv_we),
    .waddr_i(pv_waddr),
    .wdata_i(pv_wdata),
    .raddr_i(pv_raddr),
    .rdata_o(pv_rdata)
  );

  // unwritten entries read as their reset links
  assign rd_next = nx_rvld_q ? nx_rdata : epqm_pkg::next_reset(nx_raddr_q);
  assign rd_prev = pv_rvld_q ? pv_rdata : epqm_pkg::prev_reset(pv_raddr_q);

  assign op_cur       = epqm_pkg::op_e'(op_q);
  assign named_self   = (e_q == t_q);
  assign hit_anchor   = (rd_next == anchor_q);
  assign walk_end     = (rd_next == t_q) || (steps_q == StepW'(epqm_pkg::Entries));
  assign walk_hit     = (rd_next == e_q);
  assign prev_is_tail = (rd_prev == t_q);
  assign ins_base     = (op_cur == epqm_pkg::OP_FREE) ? anchor_q : t_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      epqm_pkg::S_IDLE: begin
        if (accept) begin
          state_d = epqm_pkg::S_START;
        end
      end
      epqm_pkg::S_START: begin
        unique case (op_cur)
          epqm_pkg::OP_ALLOC,
          epqm_pkg::OP_FREE: begin
            state_d = free_empty_q ? epqm_pkg::S_IDLE : epqm_pkg::S_LINK;
          end
          epqm_pkg::OP_APPEND,
          epqm_pkg::OP_PEEK,
          epqm_pkg::OP_RM_HEAD: begin
            state_d = tp_q ? epqm_pkg::S_LINK : epqm_pkg::S_IDLE;
          end
          epqm_pkg::OP_RM_NAMED: begin
            if (!tp_q) begin
              state_d = epqm_pkg::S_IDLE;
            end else if (named_self) begin
              state_d = epqm_pkg::S_UNLINK;
            end else begin
              state_d = epqm_pkg::S_WALK;
            end
          end
          default: state_d = epqm_pkg::S_IDLE;
        endcase
      end
      epqm_pkg::S_LINK: begin
        unique case (op_cur)
          epqm_pkg::OP_ALLOC: begin
            state_d = hit_anchor ? epqm_pkg::S_IDLE : epqm_pkg::S_UNLINK;
          end
          epqm_pkg::OP_FREE,
          epqm_pkg::OP_APPEND: state_d = epqm_pkg::S_INSERT;
          epqm_pkg::OP_RM_HEAD: state_d = epqm_pkg::S_UNLINK;
          default:             state_d = epqm_pkg::S_IDLE;
        endcase
      end
      epqm_pkg::S_WALK: begin
        if (walk_end) begin
          state_d = epqm_pkg::S_IDLE;
        end else if (walk_hit) begin
          state_d = epqm_pkg::S_UNLINK;
        end
      end
      epqm_pkg::S_UNLINK,
      epqm_pkg::S_INSERT: state_d = epqm_pkg::S_IDLE;
      default:           state_d = epqm_pkg::S_IDLE;
    endcase
  end

  // memory accesses and result building
  always_comb begin
    nx_we        = 1'b0;
    nx_waddr     = '0;
    nx_wdata     = '0;
    nx_raddr     = '0;
    pv_we        = 1'b0;
    pv_waddr     = '0;
    pv_wdata     = '0;
    pv_raddr     = '0;
    anchor_d     = anchor_q;
    free_empty_d = free_empty_q;
    steps_d      = steps_q;
    n_d          = n_q;
    res_d        = res_q;
    unique case (state_q)
      epqm_pkg::S_IDLE: begin
      end
      epqm_pkg::S_START: begin
        // queue untouched unless the operation says otherwise
        res_d.result_present   = 1'b0;
        res_d.result_index     = '0;
        res_d.new_tail_present = tp_q;
        res_d.new_tail_index   = t_q;
        steps_d                = '0;
        unique case (op_cur)
          epqm_pkg::OP_ALLOC: nx_raddr = anchor_q;
          epqm_pkg::OP_FREE: begin
            if (free_empty_q) begin
              // entry becomes a one-entry free list
              nx_we        = 1'b1;
              nx_waddr     = e_q;
              nx_wdata     = e_q;
              pv_we        = 1'b1;
              pv_waddr     = e_q;
              pv_wdata     = e_q;
              anchor_d     = e_q;
              free_empty_d = 1'b0;
            end else begin
              nx_raddr = anchor_q;
            end
          end
          epqm_pkg::OP_APPEND: begin
            if (!tp_q) begin
              nx_we                  = 1'b1;
              nx_waddr               = e_q;
              nx_wdata               = e_q;
              pv_we                  = 1'b1;
              pv_waddr               = e_q;
              pv_wdata               = e_q;
              res_d.new_tail_present = 1'b1;
              res_d.new_tail_index   = e_q;
            end else begin
              nx_raddr = t_q;
            end
          end
          epqm_pkg::OP_PEEK,
          epqm_pkg::OP_RM_HEAD: nx_raddr = t_q;
          epqm_pkg::OP_RM_NAMED: begin
            nx_raddr = t_q;
            pv_raddr = t_q;
          end
          default: begin
          end
        endcase
      end
      epqm_pkg::S_LINK: begin
        unique case (op_cur)
          epqm_pkg::OP_ALLOC: begin
            res_d.result_present = 1'b1;
            if (hit_anchor) begin
              // last free entry goes out
              res_d.result_index = anchor_q;
              free_empty_d       = 1'b1;
            end else begin
              res_d.result_index = rd_next;
              nx_raddr           = rd_next;
              pv_raddr           = rd_next;
            end
          end
          epqm_pkg::OP_FREE,
          epqm_pkg::OP_APPEND: begin
            // first half of the insertion after the base entry
            nx_we    = 1'b1;
            nx_waddr = e_q;
            nx_wdata = rd_next;
            pv_we    = 1'b1;
            pv_waddr = e_q;
            pv_wdata = ins_base;
            n_d      = rd_next;
          end
          epqm_pkg::OP_PEEK: begin
            res_d.result_present = 1'b1;
            res_d.result_index   = rd_next;
          end
          epqm_pkg::OP_RM_HEAD: begin
            res_d.result_present = 1'b1;
            res_d.result_index   = rd_next;
            if (rd_next == t_q) begin
              res_d.new_tail_present = 1'b0;
              res_d.new_tail_index   = '0;
            end
            nx_raddr = rd_next;
            pv_raddr = rd_next;
          end
          default: begin
          end
        endcase
      end
      epqm_pkg::S_INSERT: begin
        // second half of the insertion
        nx_we    = 1'b1;
        nx_waddr = ins_base;
        nx_wdata = e_q;
        pv_we    = 1'b1;
        pv_waddr = n_q;
        pv_wdata = e_q;
        if (op_cur == epqm_pkg::OP_APPEND) begin
          res_d.new_tail_present = 1'b1;
          res_d.new_tail_index   = e_q;
        end
      end
      epqm_pkg::S_UNLINK: begin
        // splice the neighbours of the entry together
        nx_we    = 1'b1;
        nx_waddr = rd_prev;
        nx_wdata = rd_next;
        pv_we    = 1'b1;
        pv_waddr = rd_next;
        pv_wdata = rd_prev;
        if (op_cur == epqm_pkg::OP_RM_NAMED) begin
          res_d.result_present = 1'b1;
          res_d.result_index   = e_q;
          if (named_self) begin
            if (prev_is_tail) begin
              res_d.new_tail_present = 1'b0;
              res_d.new_tail_index   = '0;
            end else begin
              res_d.new_tail_index = rd_prev;
            end
          end
        end
      end
      epqm_pkg::S_WALK: begin
        if (!walk_end) begin
          if (walk_hit) begin
            nx_raddr = e_q;
            pv_raddr = e_q;
          end else begin
            nx_raddr = rd_next;
            steps_d  = steps_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= epqm_pkg::S_IDLE;
      anchor_q     <= '0;
      free_empty_q <= 1'b0;
      done_q       <= 1'b0;
      nx_vld_q     <= '0;
      pv_vld_q     <= '0;
    end else begin
      state_q      <= state_d;
      anchor_q     <= anchor_d;
      free_empty_q <= free_empty_d;
      done_q       <= (state_q != epqm_pkg::S_IDLE) && (state_d == epqm_pkg::S_IDLE);
      if (nx_we) begin
        nx_vld_q[nx_waddr] <= 1'b1;
      end
      if (pv_we) begin
        pv_vld_q[pv_waddr] <= 1'b1;
      end
    end
  end

  // item capture, working registers and read tracking
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= req_i.operation;
      tp_q <= req_i.tail_present;
      t_q  <= req_i.tail_index;
      e_q  <= req_i.entry_index;
    end
    steps_q    <= steps_d;
    n_q        <= n_d;
    res_q      <= res_d;
    nx_raddr_q <= nx_raddr;
    pv_raddr_q <= pv_raddr;
    nx_rvld_q  <= nx_vld_q[nx_raddr];
    pv_rvld_q  <= pv_vld_q[pv_raddr];
  end

  // result port
  assign valid_o                = done_q;
  assign rsp_o.result_present   = res_q.result_present;
  assign rsp_o.result_index     = res_q.result_present ? res_q.result_index : '0;
  assign rsp_o.new_tail_present = res_q.new_tail_present;
  assign rsp_o.new_tail_index   = res_q.new_tail_present ? res_q.new_tail_index : '0;

  // checks
  `EPQM_ASSERT_NOW(a_strobe_idle, clk_i, rst_ni, valid_o, !busy)
  `EPQM_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy && !valid_o)
  `EPQM_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, valid_o, !valid_o)
  `EPQM_ASSERT_NOW(a_walk_bound, clk_i, rst_ni, state_q == epqm_pkg::S_WALK,
                   steps_q <= StepW'(epqm_pkg::Entries))

endmodule

`default_nettype wire
